FILE: src/tvr_pkg.sv
// Shared constants, types and helpers of the trilinear volume resampler.
package tvr_pkg;

  // Sizing
  localparam int MAX_DIM     = 64;
  localparam int STORE_DEPTH = 262144;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int CFG_W       = 7;
  localparam int VOX_W       = 8;
  localparam int FRAC_W      = 8;
  localparam int WGT_W       = FRAC_W + 1;
  localparam int P_W         = 2 * DIM_W;
  localparam int Q_W         = P_W + FRAC_W;
  localparam int CNT_W       = $clog2(Q_W);
  localparam int WY_W        = CFG_W + DIM_W;
  localparam int WH_W        = 2 * DIM_W + 1;
  localparam int ACC_W       = 3 * FRAC_W + VOX_W;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_DEPTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_SIZE   = 2'd3;

  // Request kinds
  localparam logic REQ_STORE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Per-axis split result: lower index, clamped upper index, fraction
  typedef struct packed {
    logic [DIM_W-1:0]  lo;
    logic [DIM_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  // Control from the sequencer to the blend pipeline
  typedef struct packed {
    logic       clear;
    logic       issue;
    logic [2:0] corner;
  } blend_ctrl_t;

  // Extent of zero reads as one, anything above MAX_DIM saturates
  function automatic logic [CFG_W-1:0] sat_extent(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > CFG_W'(MAX_DIM)) r = CFG_W'(MAX_DIM);
    return r;
  endfunction

endpackage

FILE: src/tvr_voxel_ram.sv
// Single-port voxel memory, read-first, with a registered read.
module tvr_voxel_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/tvr_axis_div.sv
// One axis: coord*(s-1) divided by (d-1), one quotient bit per cycle.
module tvr_axis_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tvr_pkg::DIM_W-1:0]  coord,
  input  logic [tvr_pkg::CFG_W-1:0]  ext,
  input  logic [tvr_pkg::CFG_W-1:0]  dst,
  output logic                       done,
  output tvr_pkg::axis_t             res
);
  import tvr_pkg::*;

  logic [Q_W-1:0]   num;      // dividend shifts out, quotient shifts in
  logic [DIM_W-1:0] rem;
  logic [DIM_W-1:0] den;
  logic [DIM_W-1:0] smax;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [CFG_W-1:0] s_sat;
  logic [DIM_W-1:0] smax_in;
  logic [DIM_W:0]   trial;
  logic             ge;
  logic [P_W-1:0]   base;

  assign s_sat   = sat_extent(ext);
  assign smax_in = DIM_W'(s_sat - CFG_W'(1));

  // Restoring step on (num << 8), so the low 8 quotient bits are the fraction
  assign trial = {rem, num[Q_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= {P_W'(coord * smax_in), FRAC_W'(0)};
      rem  <= '0;
      den  <= DIM_W'(dst - CFG_W'(1));
      smax <= smax_in;
    end else if (busy) begin
      num <= {num[Q_W-2:0], ge};
      rem <= ge ? DIM_W'(trial - {1'b0, den}) : DIM_W'(trial);
    end
  end

  // Target edge of one: base and fraction are zero
  assign base = (den == '0) ? '0 : num[Q_W-1:FRAC_W];

  always_comb begin
    res.lo   = (base > P_W'(smax)) ? smax : base[DIM_W-1:0];
    res.hi   = (res.lo == smax) ? smax : res.lo + DIM_W'(1);
    res.frac = (den == '0) ? '0 : num[FRAC_W-1:0];
  end

endmodule

FILE: src/tvr_blend.sv
// Weight and accumulate pipeline: one corner voxel enters per cycle.
module tvr_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  tvr_pkg::blend_ctrl_t        ctrl,
  input  logic [tvr_pkg::FRAC_W-1:0]  fx,
  input  logic [tvr_pkg::FRAC_W-1:0]  fy,
  input  logic [tvr_pkg::FRAC_W-1:0]  fz,
  input  logic [tvr_pkg::VOX_W-1:0]   rdata,
  output logic [tvr_pkg::ACC_W-1:0]   acc,
  output logic                        busy
);
  import tvr_pkg::*;

  logic [WGT_W-1:0]       wx, wy, wz;
  logic [2*WGT_W-1:0]     wxy;
  logic [WGT_W-1:0]       wz_q;
  logic [3*FRAC_W:0]      w3;
  logic [VOX_W-1:0]       vox;
  logic [ACC_W-1:0]       prod;
  logic                   va, vb, vc;

  // Upper corner takes f, lower corner takes 256 - f
  function automatic logic [WGT_W-1:0] wgt(input logic sel, input logic [FRAC_W-1:0] f);
    return sel ? WGT_W'(f) : WGT_W'(1 << FRAC_W) - WGT_W'(f);
  endfunction

  assign wx = wgt(ctrl.corner[0], fx);
  assign wy = wgt(ctrl.corner[1], fy);
  assign wz = wgt(ctrl.corner[2], fz);

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= ctrl.issue;
      vb <= va;
      vc <= vb;
    end
  end

  // Stage A: xy weight, in step with the memory read
  always_ff @(posedge clk) begin
    wxy  <= wx * wy;
    wz_q <= wz;
  end

  // Stage B: full weight, voxel captured
  always_ff @(posedge clk) begin
    w3  <= (3*FRAC_W+1)'(wxy * wz_q);
    vox <= rdata;
  end

  // Stage C: weighted voxel
  always_ff @(posedge clk) begin
    prod <= ACC_W'(w3 * vox);
  end

  // Stage D: running sum, 24 fraction bits
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (vc) begin
      acc <= acc + prod;
    end
  end

  assign busy = va | vb | vc;

endmodule

FILE: src/trilinear_volume_resampler.sv
// Top level: request sequencer, configuration registers and output register.
//
// Input stream (s_*): one transfer per request. A store (tuser = 0) writes one
// 8-bit voxel at a linear address in the same cycle and gives no result. A
// sample (tuser = 1) names a target grid point and gives one result transfer.
// Output stream (m_*): tdata is the interpolated voxel, tuser the range error.
// Configuration port (cfg_*): always ready; write only while the block is idle.
//
// A sample passes from acceptance to the output register through the
// per-axis bit-serial dividers (three run side by side), the address
// products, the eight corner reads on the single memory port, the drain of
// the blend pipeline and the load of the output register. An out-of-range
// sample goes straight to the finish step and on to the output register. A
// new request waits for a sample to finish; stores go one per cycle when idle.
// The output register lets the next request be taken while a result waits;
// a second sample then holds in its last step until m_tready frees the register.
// Reset (synchronous) empties the output register and restores the extents to
// 64; the voxel memory is not cleared and holds no data until written.
module trilinear_volume_resampler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // voxel_addr[17:0], voxel_value[25:18], out_x[31:26], out_y[37:32], out_z[43:38]
  input  logic [47:0]                    s_tdata,
  // req_type
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // sample_value
  output logic [tvr_pkg::VOX_W-1:0]      m_tdata,
  // range_error
  output logic                           m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tvr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tvr_pkg::CFG_W-1:0]      cfg_data
);
  import tvr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_MUL1   = 3'd2;
  localparam logic [2:0] ST_MUL2   = 3'd3;
  localparam logic [2:0] ST_FETCH  = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]        state, state_next;
  logic [CFG_W-1:0]  src_width, src_height, src_depth, dst_size;
  logic [2:0]        corner;
  logic              err;

  logic [ADDR_W-1:0] in_addr;
  logic [VOX_W-1:0]  in_value;
  logic [DIM_W-1:0]  in_x, in_y, in_z;
  logic              accept, is_sample, range_bad, div_start, div_done;
  logic              done_x, done_y, done_z;
  logic [CFG_W-1:0]  d_eff, w_sat, h_sat;
  axis_t             ax_x, ax_y, ax_z;

  logic [WY_W-1:0]   wy0, wy1;
  logic [WH_W-1:0]   wh;
  logic [ADDR_W-1:0] whz0, whz1;
  logic [ADDR_W-1:0] fetch_addr, ram_addr;
  logic [VOX_W-1:0]  rdata;
  logic              ram_we;
  logic              out_free;
  blend_ctrl_t       bctrl;
  logic [ACC_W-1:0]  acc;
  logic              blend_busy;

  // Input fields
  assign in_addr  = s_tdata[17:0];
  assign in_value = s_tdata[25:18];
  assign in_x     = s_tdata[31:26];
  assign in_y     = s_tdata[37:32];
  assign in_z     = s_tdata[43:38];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid & s_tready;
  assign is_sample = (s_tuser == REQ_SAMPLE);

  // Range check against the saturated target edge
  assign d_eff     = (dst_size > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : dst_size;
  assign range_bad = (CFG_W'(in_x) >= d_eff) || (CFG_W'(in_y) >= d_eff) ||
                     (CFG_W'(in_z) >= d_eff);
  assign div_start = accept & is_sample & ~range_bad;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= CFG_W'(MAX_DIM);
      src_height <= CFG_W'(MAX_DIM);
      src_depth  <= CFG_W'(MAX_DIM);
      dst_size   <= CFG_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_SRC_DEPTH:  src_depth  <= cfg_data;
        REG_DST_SIZE:   dst_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-axis dividers
  tvr_axis_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .coord(in_x), .ext(src_width),
    .dst(d_eff), .done(done_x), .res(ax_x)
  );
  tvr_axis_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .coord(in_y), .ext(src_height),
    .dst(d_eff), .done(done_y), .res(ax_y)
  );
  tvr_axis_div u_div_z (
    .clk(clk), .rst(rst), .start(div_start), .coord(in_z), .ext(src_depth),
    .dst(d_eff), .done(done_z), .res(ax_z)
  );
  assign div_done = done_x & done_y & done_z;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_sample) state_next = range_bad ? ST_FINISH : ST_DIV;
      end
      ST_DIV:    if (div_done) state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_FETCH;
      ST_FETCH:  if (corner == 3'd7) state_next = ST_DRAIN;
      ST_DRAIN:  if (!blend_busy) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      corner <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FETCH) corner <= corner + 3'd1;
      else corner <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_sample) err <= range_bad;
  end

  // Address products: width times y index and width times height in ST_MUL1, then that area times z index in ST_MUL2
  assign w_sat = sat_extent(src_width);
  assign h_sat = sat_extent(src_height);

  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      wy0 <= WY_W'(w_sat * ax_y.lo);
      wy1 <= WY_W'(w_sat * ax_y.hi);
      wh  <= WH_W'(w_sat * h_sat);
    end
    if (state == ST_MUL2) begin
      whz0 <= ADDR_W'(wh * ax_z.lo);
      whz1 <= ADDR_W'(wh * ax_z.hi);
    end
  end

  // Corner address, wraps modulo the store depth
  assign fetch_addr = ADDR_W'(corner[0] ? ax_x.hi : ax_x.lo) +
                      ADDR_W'(corner[1] ? wy1 : wy0) +
                      (corner[2] ? whz1 : whz0);

  assign ram_we   = accept & ~is_sample;
  assign ram_addr = (state == ST_IDLE) ? in_addr : fetch_addr;

  tvr_voxel_ram #(
    .DATA_W(VOX_W),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_value), .rdata(rdata)
  );

  // Blend pipeline
  assign bctrl.clear  = (state == ST_MUL2);
  assign bctrl.issue  = (state == ST_FETCH);
  assign bctrl.corner = corner;

  tvr_blend u_blend (
    .clk(clk), .rst(rst), .ctrl(bctrl), .fx(ax_x.frac), .fy(ax_y.frac),
    .fz(ax_z.frac), .rdata(rdata), .acc(acc), .busy(blend_busy)
  );

  // Output register
  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= err ? '0 : acc[ACC_W-1:ACC_W-VOX_W];
      m_tuser <= err;
    end
  end

endmodule
